[hdl/spq_pkg.sv]
// Shared constants and types for the strict-priority queue scheduler.
`default_nettype none
package spq_pkg;

  localparam int NUM_CLASSES      = 4;
  localparam int CLASS_BITS       = 2;
  localparam int TID_FIELD_BITS   = 16;
  localparam int TOTAL_FIELD_BITS = 7;

  localparam int DEF_QUEUE_DEPTH    = 16;
  localparam int DEF_THREAD_ID_BITS = 16;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Flags of one result, held until the next transfer.
  typedef struct packed {
    logic                  grant;
    logic [CLASS_BITS-1:0] served_class;
    logic                  overflow;
  } res_flags_t;

endpackage
`default_nettype wire

[hdl/spq_if.sv]
// Command and result channel interfaces of the scheduler.
`default_nettype none
interface spq_cmd_if;
  import spq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [TID_FIELD_BITS-1:0] thread_id;
  logic [CLASS_BITS-1:0]     priority_class;

  modport source (output valid, operation, thread_id, priority_class, input ready);
  modport sink   (input valid, operation, thread_id, priority_class, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        grant_valid;
  logic [TID_FIELD_BITS-1:0]   granted_thread;
  logic [CLASS_BITS-1:0]       served_class;
  logic                        overflow;
  logic [TOTAL_FIELD_BITS-1:0] total_waiting;

  modport source (output valid, grant_valid, granted_thread, served_class, overflow,
                  total_waiting, input ready);
  modport sink   (input valid, grant_valid, granted_thread, served_class, overflow,
                  total_waiting, output ready);
endinterface
`default_nettype wire

[hdl/spq_store.sv]
// Queue entry memory: one write port, one registered read port.
`default_nettype none
module spq_store #(
  parameter int QUEUE_DEPTH    = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = spq_pkg::DEF_THREAD_ID_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [spq_pkg::CLASS_BITS-1:0]        wcls,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0]        wptr,
  input  wire logic [THREAD_ID_BITS-1:0]             wdata,
  input  wire logic                                  re,
  input  wire logic [spq_pkg::CLASS_BITS-1:0]        rcls,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0]        rptr,
  output logic      [THREAD_ID_BITS-1:0]             rdata
);
  import spq_pkg::*;

  logic [THREAD_ID_BITS-1:0] mem [NUM_CLASSES][QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wcls][wptr] <= wdata;
    end
  end

  // Hold read data until the next pop.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[rcls][rptr];
    end
  end

endmodule
`default_nettype wire

[hdl/spq_ctrl.sv]
// Queue pointers, occupancy counts and strict-priority selection.
`default_nettype none
module spq_ctrl #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PW          = $clog2(QUEUE_DEPTH),
  parameter int TW          = $clog2(spq_pkg::NUM_CLASSES * QUEUE_DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           operation,
  input  wire logic [spq_pkg::CLASS_BITS-1:0] priority_class,
  output logic                                we,
  output logic      [spq_pkg::CLASS_BITS-1:0] wcls,
  output logic      [PW-1:0]                  wptr,
  output logic                                re,
  output logic      [spq_pkg::CLASS_BITS-1:0] rcls,
  output logic      [PW-1:0]                  rptr,
  output spq_pkg::res_flags_t                 res,
  output logic      [TW-1:0]                  total
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] head  [NUM_CLASSES];
  logic [PW-1:0] tail  [NUM_CLASSES];
  logic [CW-1:0] count [NUM_CLASSES];

  logic                  full;
  logic                  found;
  logic [CLASS_BITS-1:0] sel;
  logic [PW-1:0]         tail_adv;
  logic [PW-1:0]         head_adv;
  res_flags_t            res_next;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        sel   = CLASS_BITS'(i);
      end
    end
  end

  assign full     = (count[priority_class] == CW'(QUEUE_DEPTH));
  assign tail_adv = (tail[priority_class] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : tail[priority_class] + 1'b1;
  assign head_adv = (head[sel] == PW'(QUEUE_DEPTH - 1)) ? '0 : head[sel] + 1'b1;

  assign we   = accept && (operation == OP_ENQUEUE) && !full;
  assign wcls = priority_class;
  assign wptr = tail[priority_class];
  assign re   = accept && (operation == OP_DEQUEUE) && found;
  assign rcls = sel;
  assign rptr = head[sel];

  always_comb begin
    res_next = '0;
    if (operation == OP_ENQUEUE) begin
      res_next.overflow = full;
    end else if (found) begin
      res_next.grant        = 1'b1;
      res_next.served_class = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
      total <= '0;
      res   <= '0;
    end else if (accept) begin
      res <= res_next;
      if (we) begin
        tail[priority_class]  <= tail_adv;
        count[priority_class] <= count[priority_class] + 1'b1;
        total                 <= total + 1'b1;
      end
      if (re) begin
        head[sel]  <= head_adv;
        count[sel] <= count[sel] - 1'b1;
        total      <= total - 1'b1;
      end
    end
  end

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    total == TW'(count[0]) + TW'(count[1]) + TW'(count[2]) + TW'(count[3]))
    else $error("running total disagrees with class counts");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(res.grant && res.overflow))
    else $error("grant and overflow set together");

  a_enqueue_no_grant: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_ENQUEUE) |=> !res.grant)
    else $error("enqueue produced a grant");

  a_empty_no_grant: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_DEQUEUE) && (total == '0) |=> !res.grant && (total == '0))
    else $error("dequeue from empty queues granted");

  a_no_overflow_room: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_ENQUEUE) && (count[priority_class] < CW'(QUEUE_DEPTH))
    |=> !res.overflow && (total == $past(total) + 1'b1))
    else $error("enqueue with room was dropped");

endmodule
`default_nettype wire

[hdl/strict_priority_four_queue_scheduler.sv]
// Top level of the four-class strict-priority thread queue scheduler.
//
// Usage: cmd carries one command per transfer. operation OP_ENQUEUE appends
// thread_id to the FIFO of priority_class (0 highest); OP_DEQUEUE pops the
// head of the highest class that holds a thread. rsp carries exactly one
// result per command: grant flag, popped thread and its class, overflow
// (enqueue into a full class queue, thread dropped) and the total held.
// Latency: a result is valid the cycle after its command transfers; the
// popped identifier comes straight from the read register of the entry
// memory, read in the command's cycle.
// Throughput: one command per cycle. cmd.ready is high while the result
// register is empty or its result transfers in the same cycle; that single
// result register, refilled in the cycle it drains, sets the figure.
// Reset (rst, synchronous): all queues empty, no result pending. No
// clearing pass is needed; the entry memory is read only where written.
// When rsp stalls, the result holds and cmd.ready drops until it transfers.
`default_nettype none
module strict_priority_four_queue_scheduler #(
  parameter int QUEUE_DEPTH    = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_ID_BITS = spq_pkg::DEF_THREAD_ID_BITS
) (
  input wire logic clk,
  input wire logic rst,
  spq_cmd_if.sink   cmd,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int TW = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);

  logic                      accept;
  logic                      rsp_valid;
  logic                      we;
  logic [CLASS_BITS-1:0]     wcls;
  logic [PW-1:0]             wptr;
  logic                      re;
  logic [CLASS_BITS-1:0]     rcls;
  logic [PW-1:0]             rptr;
  logic [THREAD_ID_BITS-1:0] wdata;
  logic [THREAD_ID_BITS-1:0] rdata;
  logic [31:0]               tid_ext;
  logic [31:0]               rdata_ext;
  logic [31:0]               total_ext;
  logic [TW-1:0]             total;
  res_flags_t                res;

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Drop identifier bits above the stored width.
  assign tid_ext = 32'(cmd.thread_id);
  assign wdata   = tid_ext[THREAD_ID_BITS-1:0];

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PW          (PW),
    .TW          (TW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .operation      (cmd.operation),
    .priority_class (cmd.priority_class),
    .we             (we),
    .wcls           (wcls),
    .wptr           (wptr),
    .re             (re),
    .rcls           (rcls),
    .rptr           (rptr),
    .res            (res),
    .total          (total)
  );

  spq_store #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .wcls  (wcls),
    .wptr  (wptr),
    .wdata (wdata),
    .re    (re),
    .rcls  (rcls),
    .rptr  (rptr),
    .rdata (rdata)
  );

  assign rdata_ext = 32'(rdata);
  assign total_ext = 32'(total);

  assign rsp.valid          = rsp_valid;
  assign rsp.grant_valid    = res.grant;
  assign rsp.granted_thread = res.grant ? rdata_ext[TID_FIELD_BITS-1:0] : '0;
  assign rsp.served_class   = res.served_class;
  assign rsp.overflow       = res.overflow;
  assign rsp.total_waiting  = total_ext[TOTAL_FIELD_BITS-1:0];

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the four-class strict-priority thread scheduler.
`default_nettype none
module testbench;
  import spq_pkg::*;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int ID_BITS     = DEF_THREAD_ID_BITS;
  localparam int RANDOM_CMDS = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 500;

  typedef struct packed {
    logic                        op;
    logic [TID_FIELD_BITS-1:0]   tid;
    logic [CLASS_BITS-1:0]       cls;
  } sched_cmd_t;

  typedef struct packed {
    logic                        grant;
    logic [TID_FIELD_BITS-1:0]   thread;
    logic [CLASS_BITS-1:0]       served;
    logic                        ovf;
    logic [TOTAL_FIELD_BITS-1:0] total;
  } sched_result_t;

  logic clk;
  logic rst;

  spq_cmd_if cmd_ch();
  spq_rsp_if rsp_ch();

  strict_priority_four_queue_scheduler #(
    .QUEUE_DEPTH   (DEPTH),
    .THREAD_ID_BITS(ID_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  // Mirror of the class FIFOs.
  logic [TID_FIELD_BITS-1:0] class_slots [NUM_CLASSES][DEPTH];
  int unsigned slot_rd   [NUM_CLASSES] = '{default: 0};
  int unsigned slot_wr   [NUM_CLASSES] = '{default: 0};
  int unsigned slot_fill [NUM_CLASSES] = '{default: 0};

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];

  bit cmd_taken = 1'b0;
  int send_gap = 0;
  bit send_calm = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  bit recv_calm = 1'b0;

  int cycles = 0;
  int total_cmds = 0;
  int accepted = 0;
  int checked = 0;
  int mismatches = 0;
  int n_enq = 0;
  int n_drop = 0;
  int n_deq = 0;
  int n_grant = 0;
  int n_empty = 0;
  int peak_total = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sched_result_t predict_schedule(sched_cmd_t c);
    sched_result_t r;
    int unsigned sum;
    int k;
    bit served;
    logic [TID_FIELD_BITS-1:0] id_mask;
    r = '0;
    served = 1'b0;
    sum = 0;
    id_mask = TID_FIELD_BITS'((64'd1 << ID_BITS) - 1);
    if (c.op == OP_ENQUEUE) begin
      if (slot_fill[c.cls] >= DEPTH) begin
        r.ovf = 1'b1;
      end else begin
        class_slots[c.cls][slot_wr[c.cls]] = c.tid & id_mask;
        slot_wr[c.cls] = (slot_wr[c.cls] + 1) % DEPTH;
        slot_fill[c.cls]++;
      end
    end else begin
      // Lowest class index wins.
      for (k = 0; k < NUM_CLASSES; k++) begin
        if (!served && slot_fill[k] != 0) begin
          served = 1'b1;
          r.grant = 1'b1;
          r.thread = class_slots[k][slot_rd[k]];
          r.served = CLASS_BITS'(k);
          slot_rd[k] = (slot_rd[k] + 1) % DEPTH;
          slot_fill[k]--;
        end
      end
    end
    for (k = 0; k < NUM_CLASSES; k++) sum += slot_fill[k];
    r.total = TOTAL_FIELD_BITS'(sum);
    return r;
  endfunction

  function automatic int idle_len(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic plan_command(input logic op, input logic [TID_FIELD_BITS-1:0] tid,
                              input logic [CLASS_BITS-1:0] cls);
    sched_cmd_t c;
    c.op = op;
    c.tid = tid;
    c.cls = cls;
    pending_cmds.push_back(c);
  endtask

  // Command driver: hold the current command until it transfers, then idle a while.
  always @(negedge clk) begin : cmd_driver
    sched_cmd_t next_cmd;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_taken) begin
      // hold
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      cmd_ch.valid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      next_cmd = pending_cmds.pop_front();
      cmd_ch.valid <= 1'b1;
      cmd_ch.operation <= next_cmd.op;
      cmd_ch.thread_id <= next_cmd.tid;
      cmd_ch.priority_class <= next_cmd.cls;
      send_gap <= idle_len(send_calm);
      if ($urandom_range(0, 40) == 0) send_calm <= !send_calm;
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the block.
  always @(negedge clk) begin : rsp_receiver
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!pressure_done && checked >= 300) begin
      pressure_done <= 1'b1;
      hold_left <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!recv_calm && $urandom_range(0, 5) == 0) begin
      stall_left <= idle_len(1'b0);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
    if ($urandom_range(0, 200) == 0) recv_calm <= !recv_calm;
  end

  // Monitor: predict on each command transfer, check each result transfer.
  always @(posedge clk) begin : monitor
    sched_cmd_t    seen;
    sched_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("grant_valid", 32'(want.grant), 32'(rsp_ch.grant_valid));
          check_field("granted_thread", 32'(want.thread), 32'(rsp_ch.granted_thread));
          check_field("served_class", 32'(want.served), 32'(rsp_ch.served_class));
          check_field("overflow", 32'(want.ovf), 32'(rsp_ch.overflow));
          check_field("total_waiting", 32'(want.total), 32'(rsp_ch.total_waiting));
          checked++;
        end
      end
      if (!rst && cmd_ch.valid && cmd_ch.ready) begin
        seen.op = cmd_ch.operation;
        seen.tid = cmd_ch.thread_id;
        seen.cls = cmd_ch.priority_class;
        want = predict_schedule(seen);
        expected_results.push_back(want);
        accepted++;
        if (seen.op == OP_ENQUEUE) begin
          n_enq++;
          if (want.ovf) n_drop++;
        end else begin
          n_deq++;
          if (want.grant) n_grant++;
          else n_empty++;
        end
        if (int'(want.total) > peak_total) peak_total = int'(want.total);
      end
    end
  end

  initial begin : stimulus
    int roll;
    int len;
    int k;
    int cls;
    int random_end;
    bit first;
    clk = 1'b0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_ENQUEUE;
    cmd_ch.thread_id = '0;
    cmd_ch.priority_class = '0;
    rsp_ch.ready = 1'b0;

    // Directed: empty dequeue, extreme IDs, priority order, FIFO order per class.
    plan_command(OP_DEQUEUE, 16'hFFFF, 2'd3);
    plan_command(OP_ENQUEUE, 16'hFFFF, 2'd3);
    plan_command(OP_ENQUEUE, 16'h0000, 2'd2);
    plan_command(OP_ENQUEUE, 16'h8001, 2'd1);
    plan_command(OP_ENQUEUE, 16'h7FFE, 2'd0);
    plan_command(OP_ENQUEUE, 16'h1234, 2'd3);
    repeat (5) plan_command(OP_DEQUEUE, 16'h0000, 2'd0);
    plan_command(OP_DEQUEUE, 16'hFFFF, 2'd2);
    plan_command(OP_ENQUEUE, 16'hFFFF, 2'd0);
    plan_command(OP_ENQUEUE, 16'h0000, 2'd0);
    plan_command(OP_DEQUEUE, 16'h5A5A, 2'd1);
    plan_command(OP_DEQUEUE, 16'hA5A5, 2'd3);
    plan_command(OP_ENQUEUE, 16'hAAAA, 2'd2);
    plan_command(OP_ENQUEUE, 16'h5555, 2'd1);
    plan_command(OP_DEQUEUE, 16'h0000, 2'd0);
    plan_command(OP_ENQUEUE, 16'h0F0F, 2'd0);
    plan_command(OP_DEQUEUE, 16'h0000, 2'd0);
    plan_command(OP_DEQUEUE, 16'h0000, 2'd0);
    plan_command(OP_DEQUEUE, 16'hFFFF, 2'd3);

    // Random: mostly fill and drain runs with random IDs, some noise.
    random_end = pending_cmds.size() + RANDOM_CMDS;
    first = 1'b1;
    while (pending_cmds.size() < random_end) begin
      roll = first ? 80 : $urandom_range(0, 99);
      first = 1'b0;
      if (roll < 30) begin
        len = $urandom_range(4, 30);
        repeat (len) plan_command(1'($urandom_range(0, 1)), TID_FIELD_BITS'($urandom),
                                  CLASS_BITS'($urandom_range(0, 3)));
      end else if (roll < 55) begin
        cls = $urandom_range(0, 3);
        len = $urandom_range(1, 20);
        repeat (len) plan_command(OP_ENQUEUE, TID_FIELD_BITS'($urandom), CLASS_BITS'(cls));
      end else if (roll < 75) begin
        len = $urandom_range(1, 40);
        repeat (len) plan_command(OP_DEQUEUE, TID_FIELD_BITS'($urandom),
                                  CLASS_BITS'($urandom_range(0, 3)));
      end else if (roll < 85) begin
        // Overfill every class, then drain past empty.
        repeat (DEPTH + 2) begin
          for (k = 0; k < NUM_CLASSES; k++) begin
            plan_command(OP_ENQUEUE, TID_FIELD_BITS'($urandom), CLASS_BITS'(k));
          end
        end
        repeat (NUM_CLASSES * DEPTH + 4) begin
          plan_command(OP_DEQUEUE, TID_FIELD_BITS'($urandom),
                       CLASS_BITS'($urandom_range(0, 3)));
        end
      end else begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          plan_command(($urandom_range(0, 3) == 0) ? OP_DEQUEUE : OP_ENQUEUE,
                       TID_FIELD_BITS'($urandom), CLASS_BITS'($urandom_range(0, 3)));
        end
      end
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted < total_cmds || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d commands: %0d enqueues (%0d dropped on a full class),",
             accepted, n_enq, n_drop);
    $display("%0d dequeues (%0d granted, %0d on empty), peak occupancy %0d of %0d",
             n_deq, n_grant, n_empty, peak_total, NUM_CLASSES * DEPTH);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[strict_priority_four_queue_scheduler.f]
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_store.sv
hdl/spq_ctrl.sv
hdl/strict_priority_four_queue_scheduler.sv
tb/testbench.sv
